// File: design/euler_zyz_rotation_matrix_defines.svh
// Assertion helpers for the rotation-matrix pipeline.
`ifndef EULER_ZYZ_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ZYZ_ROTATION_MATRIX_DEFINES_SVH

// Check an implication on every clock edge outside reset.
`define EZR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a value stays within the unit range while it is shown.
`define EZR_ASSERT_UNIT(lbl, vld, val, msg) \
  `EZR_ASSERT(lbl, vld |-> ((val <= 18'sd65536) && (val >= -18'sd65536)), msg)

`endif

// File: design/ezr_pkg.sv
`default_nettype none
package ezr_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int IN_BITS      = 16;
  localparam int OUT_BITS     = 18;
  localparam int OUT_FRAC     = 16;
  localparam int CORDIC_STEPS = 31;
  localparam int WORK_FRAC    = 30;
  localparam int WW           = 33;
  localparam int CW           = FRAC_BITS + 2;
  localparam int PW           = 2 * CW;
  localparam int TABLE_LEN    = 11;

  localparam logic signed [WW-1:0] CORDIC_GAIN  = WW'(652032874);
  localparam longint               TURN_PER_RAD = 683565276;
  localparam logic signed [CW-1:0] ONE          = CW'(1) <<< FRAC_BITS;
  localparam logic signed [OUT_BITS-1:0] OUT_ONE = OUT_BITS'(65536);

  localparam longint ATAN_TURNS [TABLE_LEN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544
  };

  typedef logic signed [WW-1:0] work_t;
  typedef logic signed [CW-1:0] trig_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [PW:0]   sum_t;
  typedef logic signed [OUT_BITS-1:0] ent_t;

  function automatic work_t cordic_step(input int i);
    longint v;
    begin
      if (i < TABLE_LEN) v = ATAN_TURNS[i];
      else v = (TURN_PER_RAD + (longint'(1) << (i - 1))) >>> i;
      return WW'(v);
    end
  endfunction

  function automatic trig_t round_clamp(input work_t v);
    logic signed [WW:0] r;
    begin
      r = (WW+1)'(v) + ((WW+1)'(1) <<< (WORK_FRAC - FRAC_BITS - 1));
      r = r >>> (WORK_FRAC - FRAC_BITS);
      if (r > (WW+1)'(ONE)) return ONE;
      else if (r < -(WW+1)'(ONE)) return -ONE;
      else return CW'(r);
    end
  endfunction

  function automatic trig_t mulr(input trig_t a, input trig_t b);
    prod_t p;
    begin
      p = PW'(a) * PW'(b);
      p = (p + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return CW'(p);
    end
  endfunction

  function automatic ent_t to_out(input sum_t v);
    sum_t w;
    begin
      if (FRAC_BITS > OUT_FRAC)
        w = (v + ((PW+1)'(1) <<< (FRAC_BITS - OUT_FRAC - 1))) >>> (FRAC_BITS - OUT_FRAC);
      else
        w = v <<< (OUT_FRAC - FRAC_BITS);
      if (w > (PW+1)'(OUT_ONE)) return OUT_ONE;
      else if (w < -(PW+1)'(OUT_ONE)) return -OUT_ONE;
      else return OUT_BITS'(w);
    end
  endfunction

endpackage
`default_nettype wire

// File: design/euler_zyz_rotation_matrix.sv
// ZYZ Euler rotation matrix: takes alpha, beta, gamma phase words (full range is
// one turn) and returns the nine entries of Rz(alpha)*Ry(beta)*Rz(gamma) with
// 16 fraction bits, saturated to +-1.0. One beat enters per clock unless stalled;
// stages are input load, the 31 registered CORDIC iterations run in parallel for
// the three angles, quadrant fold, first matrix product, multiply and sum. A high
// stall_i on a shown result freezes the whole pipeline; nothing else holds it.
`default_nettype none
`include "euler_zyz_rotation_matrix_defines.svh"
module euler_zyz_rotation_matrix (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  output logic                                     stall_o,
  input  wire logic [ezr_pkg::IN_BITS-1:0]         angle_first_z_i,
  input  wire logic [ezr_pkg::IN_BITS-1:0]         angle_middle_y_i,
  input  wire logic [ezr_pkg::IN_BITS-1:0]         angle_last_z_i,
  output logic                                     valid_o,
  input  wire logic                                stall_i,
  output logic signed [ezr_pkg::OUT_BITS-1:0]      m00_o,
  output logic signed [ezr_pkg::OUT_BITS-1:0]      m01_o,
  output logic signed [ezr_pkg::OUT_BITS-1:0]      m02_o,
  output logic signed [ezr_pkg::OUT_BITS-1:0]      m10_o,
  output logic signed [ezr_pkg::OUT_BITS-1:0]      m11_o,
  output logic signed [ezr_pkg::OUT_BITS-1:0]      m12_o,
  output logic signed [ezr_pkg::OUT_BITS-1:0]      m20_o,
  output logic signed [ezr_pkg::OUT_BITS-1:0]      m21_o,
  output logic signed [ezr_pkg::OUT_BITS-1:0]      m22_o
);

  localparam int NS = ezr_pkg::CORDIC_STEPS;
  localparam int NV = NS + 5;

  logic                 adv;
  logic [NV-1:0]        vld_q;
  ezr_pkg::work_t       cx_q [3][NS+1];
  ezr_pkg::work_t       cy_q [3][NS+1];
  ezr_pkg::work_t       cz_q [3][NS+1];
  logic [1:0]           quad_q [3][NS+1];
  logic [ezr_pkg::ANGLE_BITS-1:0] ang [3];

  ezr_pkg::trig_t       c_q [3];
  ezr_pkg::trig_t       s_q [3];
  ezr_pkg::trig_t       cw [3];
  ezr_pkg::trig_t       sw [3];

  ezr_pkg::trig_t       t_q [3][3];
  ezr_pkg::trig_t       cg_q;
  ezr_pkg::trig_t       sg_q;

  ezr_pkg::prod_t       pa_q [3];
  ezr_pkg::prod_t       pb_q [3];
  ezr_pkg::prod_t       pc_q [3];
  ezr_pkg::prod_t       pd_q [3];
  ezr_pkg::trig_t       t2_q [3];

  ezr_pkg::ent_t        m_q [3][3];

  assign adv     = !(vld_q[NV-1] && stall_i);
  assign stall_o = !adv;
  assign valid_o = vld_q[NV-1];

  assign ang[0] = ezr_pkg::ANGLE_BITS'(angle_first_z_i);
  assign ang[1] = ezr_pkg::ANGLE_BITS'(angle_middle_y_i);
  assign ang[2] = ezr_pkg::ANGLE_BITS'(angle_last_z_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NV-2:0], valid_i};
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [31:0] ph;
    assign ph = {ang[l], {(32 - ezr_pkg::ANGLE_BITS){1'b0}}};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_q[l][0]   <= ezr_pkg::CORDIC_GAIN;
        cy_q[l][0]   <= '0;
        cz_q[l][0]   <= ezr_pkg::WW'({1'b0, ph[29:0]});
        quad_q[l][0] <= ph[31:30];
      end
    end

    for (genvar k = 0; k < NS; k++) begin : g_iter
      always_ff @(posedge clk_i) begin
        if (adv) begin
          quad_q[l][k+1] <= quad_q[l][k];
          if (!cz_q[l][k][ezr_pkg::WW-1]) begin
            cx_q[l][k+1] <= cx_q[l][k] - (cy_q[l][k] >>> k);
            cy_q[l][k+1] <= cy_q[l][k] + (cx_q[l][k] >>> k);
            cz_q[l][k+1] <= cz_q[l][k] - ezr_pkg::cordic_step(k);
          end else begin
            cx_q[l][k+1] <= cx_q[l][k] + (cy_q[l][k] >>> k);
            cy_q[l][k+1] <= cy_q[l][k] - (cx_q[l][k] >>> k);
            cz_q[l][k+1] <= cz_q[l][k] + ezr_pkg::cordic_step(k);
          end
        end
      end
    end

    assign cw[l] = ezr_pkg::round_clamp(cx_q[l][NS]);
    assign sw[l] = ezr_pkg::round_clamp(cy_q[l][NS]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        unique case (quad_q[l][NS])
          2'd0: begin c_q[l] <= cw[l];  s_q[l] <= sw[l];  end
          2'd1: begin c_q[l] <= -sw[l]; s_q[l] <= cw[l];  end
          2'd2: begin c_q[l] <= -cw[l]; s_q[l] <= -sw[l]; end
          default: begin c_q[l] <= sw[l]; s_q[l] <= -cw[l]; end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q[0][0] <= ezr_pkg::mulr(c_q[0], c_q[1]);
      t_q[0][1] <= -s_q[0];
      t_q[0][2] <= ezr_pkg::mulr(c_q[0], s_q[1]);
      t_q[1][0] <= ezr_pkg::mulr(s_q[0], c_q[1]);
      t_q[1][1] <= c_q[0];
      t_q[1][2] <= ezr_pkg::mulr(s_q[0], s_q[1]);
      t_q[2][0] <= -s_q[1];
      t_q[2][1] <= '0;
      t_q[2][2] <= c_q[1];
      cg_q      <= c_q[2];
      sg_q      <= s_q[2];
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    ezr_pkg::sum_t sum0;
    ezr_pkg::sum_t sum1;
    ezr_pkg::sum_t half;
    assign half = (ezr_pkg::PW+1)'(1) <<< (ezr_pkg::FRAC_BITS - 1);
    assign sum0 = (ezr_pkg::PW+1)'(pa_q[r]) + (ezr_pkg::PW+1)'(pb_q[r]) + half;
    assign sum1 = (ezr_pkg::PW+1)'(pc_q[r]) - (ezr_pkg::PW+1)'(pd_q[r]) + half;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pa_q[r] <= ezr_pkg::PW'(t_q[r][0]) * ezr_pkg::PW'(cg_q);
        pb_q[r] <= ezr_pkg::PW'(t_q[r][1]) * ezr_pkg::PW'(sg_q);
        pc_q[r] <= ezr_pkg::PW'(t_q[r][1]) * ezr_pkg::PW'(cg_q);
        pd_q[r] <= ezr_pkg::PW'(t_q[r][0]) * ezr_pkg::PW'(sg_q);
        t2_q[r] <= t_q[r][2];
        m_q[r][0] <= ezr_pkg::to_out(sum0 >>> ezr_pkg::FRAC_BITS);
        m_q[r][1] <= ezr_pkg::to_out(sum1 >>> ezr_pkg::FRAC_BITS);
        m_q[r][2] <= ezr_pkg::to_out((ezr_pkg::PW+1)'(t2_q[r]));
      end
    end
  end

  assign m00_o = m_q[0][0];
  assign m01_o = m_q[0][1];
  assign m02_o = m_q[0][2];
  assign m10_o = m_q[1][0];
  assign m11_o = m_q[1][1];
  assign m12_o = m_q[1][2];
  assign m20_o = m_q[2][0];
  assign m21_o = m_q[2][1];
  assign m22_o = m_q[2][2];

  `EZR_ASSERT(a_stall_only_on_held_beat, stall_o |-> (valid_o && stall_i), "stall without held beat")
  `EZR_ASSERT(a_beat_advances, (!stall_o && vld_q[NV-2]) |=> valid_o, "beat lost at output")
  `EZR_ASSERT(a_stall_freezes_pipe, stall_o |=> $stable(vld_q), "pipeline moved under stall")
  `EZR_ASSERT_UNIT(a_m00_unit, valid_o, m00_o, "m00 outside unit range")
  `EZR_ASSERT_UNIT(a_m22_unit, valid_o, m22_o, "m22 outside unit range")

endmodule
`default_nettype wire

// File: dv/euler_zyz_rotation_matrix_tb.sv
`default_nettype none
module euler_zyz_rotation_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [ezr_pkg::OUT_BITS-1:0] m [9];
  } rot_mat_t;

  class rot_scoreboard;
    rot_mat_t pending_mats[$];
    int       n_errors;

    function longint rnd_shift(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clamp_l(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void phase_cos_sin(logic [ezr_pkg::IN_BITS-1:0] ang, output longint c,
                                output longint s);
      longint x, y, z, stp, dx, dy, cw, sw, one;
      logic [31:0] ph;
      logic [1:0] q;
      ph  = {ang, 16'h0};
      q   = ph[31:30];
      z   = longint'(ph[29:0]);
      x   = 652032874;
      y   = 0;
      one = longint'(1) << ezr_pkg::FRAC_BITS;
      for (int i = 0; i < ezr_pkg::CORDIC_STEPS; i++) begin
        if (i < ezr_pkg::TABLE_LEN) stp = ezr_pkg::ATAN_TURNS[i];
        else stp = (longint'(683565276) + (longint'(1) << (i - 1))) >>> i;
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - stp;
        end else begin
          x = x + dx; y = y - dy; z = z + stp;
        end
      end
      cw = clamp_l(rnd_shift(x, ezr_pkg::WORK_FRAC - ezr_pkg::FRAC_BITS), one);
      sw = clamp_l(rnd_shift(y, ezr_pkg::WORK_FRAC - ezr_pkg::FRAC_BITS), one);
      case (q)
        2'd0: begin c = cw;  s = sw;  end
        2'd1: begin c = -sw; s = cw;  end
        2'd2: begin c = -cw; s = -sw; end
        default: begin c = sw; s = -cw; end
      endcase
    endfunction

    function logic signed [ezr_pkg::OUT_BITS-1:0] entry_out(longint v);
      return ezr_pkg::OUT_BITS'(clamp_l(v, 65536));
    endfunction

    function void note_angles(logic [15:0] a, logic [15:0] b, logic [15:0] g);
      longint ca, sa, cb, sb, cg, sg, c0, c1;
      longint t [3][3];
      rot_mat_t r;
      phase_cos_sin(a, ca, sa);
      phase_cos_sin(b, cb, sb);
      phase_cos_sin(g, cg, sg);
      t[0][0] = rnd_shift(ca * cb, ezr_pkg::FRAC_BITS); t[0][1] = -sa;
      t[0][2] = rnd_shift(ca * sb, ezr_pkg::FRAC_BITS);
      t[1][0] = rnd_shift(sa * cb, ezr_pkg::FRAC_BITS); t[1][1] = ca;
      t[1][2] = rnd_shift(sa * sb, ezr_pkg::FRAC_BITS);
      t[2][0] = -sb; t[2][1] = 0; t[2][2] = cb;
      for (int row = 0; row < 3; row++) begin
        c0 = rnd_shift(t[row][0] * cg + t[row][1] * sg, ezr_pkg::FRAC_BITS);
        c1 = rnd_shift(t[row][1] * cg - t[row][0] * sg, ezr_pkg::FRAC_BITS);
        r.m[row*3]   = entry_out(c0);
        r.m[row*3+1] = entry_out(c1);
        r.m[row*3+2] = entry_out(t[row][2]);
      end
      pending_mats.push_back(r);
    endfunction

    function void check_matrix(rot_mat_t got);
      rot_mat_t exp_m;
      if (pending_mats.size() == 0) begin
        $error("unexpected matrix beat");
        n_errors++;
        return;
      end
      exp_m = pending_mats.pop_front();
      for (int k = 0; k < 9; k++)
        if (got.m[k] !== exp_m.m[k]) begin
          $error("m%0d%0d expected %0d actual %0d", k / 3, k % 3, exp_m.m[k], got.m[k]);
          n_errors++;
        end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o;
  logic [15:0] angle_first_z_i = '0, angle_middle_y_i = '0, angle_last_z_i = '0;
  logic signed [ezr_pkg::OUT_BITS-1:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o;
  logic signed [ezr_pkg::OUT_BITS-1:0] m20_o, m21_o, m22_o;

  rot_scoreboard sb = new();
  bit  drive_done = 0;
  bit  long_hold = 0;
  int  idle_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  euler_zyz_rotation_matrix DUT (.*);

  always @(posedge clk_i) begin
    rot_mat_t got;
    if (rst_ni) begin
      if (valid_i && !stall_o)
        sb.note_angles(angle_first_z_i, angle_middle_y_i, angle_last_z_i);
      if (valid_o && !stall_i) begin
        got.m = '{m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o};
        sb.check_matrix(got);
      end
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (long_hold) stall_i <= 1'b1;
    else stall_i <= ($urandom_range(0, 99) < 30) && ($time % 4000 < 2800);
  end

  initial begin
    wait (rst_ni);
    repeat (300) @(negedge clk_i);
    long_hold = 1;
    repeat (120) @(negedge clk_i);
    long_hold = 0;
  end

  task automatic send_angles(logic [15:0] a, logic [15:0] b, logic [15:0] g);
    valid_i          <= 1'b1;
    angle_first_z_i  <= a;
    angle_middle_y_i <= b;
    angle_last_z_i   <= g;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 6) - 3);
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] corners [10];
    int burst;
    int gap;
    corners = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF, 16'h7FFF,
                16'h2000, 16'hAAAA, 16'h5555};
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int k = 0; k < 22; k++)
      send_angles(corners[k % 10], corners[(k * 3 + 1) % 10], corners[(k * 7 + 2) % 10]);
    for (int n = 0; n < 1250; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++, n++)
        send_angles(pick_angle(), pick_angle(), pick_angle());
      gap = (n > 100 && n < 400) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    valid_i <= 1'b0;
    while (sb.pending_mats.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.n_errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+design
design/ezr_pkg.sv
design/euler_zyz_rotation_matrix.sv
dv/euler_zyz_rotation_matrix_tb.sv
